/* src/ple_pkg.sv */
// shared types and constants for the positional list engine
// no dependencies
package ple_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_GET    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

/* src/positional_list_engine_core.sv */
// positional list engine top level: request decode, shift sequencer and result port
// depends on ple_pkg and ple_ram
//
// Ordered list of signed 32-bit values in a store of CAPACITY slots. A request is
// taken when start is high and busy is low; its result appears on status_o,
// data_o and count_o for exactly one cycle, marked by done_o, and cannot be held
// off by the receiver, so it must be captured in that cycle. A push and any
// rejected request (bad position or full list) give their result in the cycle
// after the request edge; a get reads the entry in S_RD and returns it from S_WR.
// An insert or a delete moves the later entries one slot at a time through the
// entry store, each moved entry a read (S_RD) and then a write (S_WR), and ends in
// S_FIN; at most CAPACITY-1 entries are moved. busy stays high while a request is
// in progress. No clearing pass is needed after reset: data of slots at or beyond
// the current length is never used.
module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ACTION_W-1:0]       action_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic signed [DATA_W-1:0]  value_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic signed [DATA_W-1:0]  data_o,
  output logic [COUNT_W-1:0]        count_o
);

  // slot address width, length width and a compare width wide enough for both
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_FIN
  } state_e;

  state_e            state_q;
  action_e           op_q;
  logic [DATA_W-1:0] val_q;
  logic [CW-1:0]     rd_q;
  logic [CW-1:0]     wr_q;
  logic [CW-1:0]     left_q;
  logic [CW-1:0]     fill_q;
  logic              done_q;
  status_e           status_q;
  logic [DATA_W-1:0] data_q;

  // request decode
  action_e       act;
  logic          accept;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] fill_x;
  logic          pos_zero;
  logic          full;
  logic          ins_bad;
  logic          at_bad;
  logic [CW-1:0] pos_m1;
  logic [CW-1:0] left_ins;
  logic [CW-1:0] left_del;

  // shared index step: walks down for insert, up for delete
  logic [CW-1:0] rd_step;

  // memory port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  assign act      = action_e'(action_i);
  assign accept   = start && (state_q == S_IDLE);
  assign pos_x    = XW'(position_i);
  assign fill_x   = XW'(fill_q);
  assign pos_zero = (position_i == '0);
  assign full     = (fill_q == CW'(CAPACITY));
  // insert may land one past the last entry
  assign ins_bad  = pos_zero || (pos_x > (fill_x + XW'(1)));
  assign at_bad   = pos_zero || (pos_x > fill_x);
  assign pos_m1   = CW'(pos_x - XW'(1));
  assign left_ins = CW'(fill_x - pos_x + XW'(1));
  assign left_del = CW'(fill_x - pos_x);

  assign rd_step = (op_q == ACT_INSERT) ? (rd_q - CW'(1)) : (rd_q + CW'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_q[AW-1:0];
    mem_wdata = mem_rdata;
    case (state_q)
      S_IDLE: begin
        if (accept && (act == ACT_PUSH) && !full) begin
          mem_we    = 1'b1;
          mem_waddr = fill_q[AW-1:0];
          mem_wdata = value_i;
        end
      end
      S_WR: begin
        // copy of the entry read in the previous cycle
        mem_we = (op_q != ACT_GET);
      end
      S_FIN: begin
        // new value into the slot that the shift opened
        if (op_q == ACT_INSERT) begin
          mem_we    = 1'b1;
          mem_wdata = val_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ple_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= ACT_PUSH;
      val_q    <= '0;
      rd_q     <= '0;
      wr_q     <= '0;
      left_q   <= '0;
      fill_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      data_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q  <= act;
            val_q <= value_i;
            case (act)
              ACT_PUSH: begin
                done_q <= 1'b1;
                if (full) begin
                  status_q <= ST_FULL;
                  data_q   <= '0;
                end else begin
                  fill_q   <= fill_q + CW'(1);
                  status_q <= ST_OK;
                  data_q   <= value_i;
                end
              end
              ACT_INSERT: begin
                // range test comes before the full test
                if (ins_bad || full) begin
                  done_q   <= 1'b1;
                  status_q <= ins_bad ? ST_RANGE : ST_FULL;
                  data_q   <= '0;
                end else begin
                  rd_q    <= fill_q - CW'(1);
                  wr_q    <= fill_q;
                  left_q  <= left_ins;
                  state_q <= (left_ins == '0) ? S_FIN : S_RD;
                end
              end
              ACT_DELETE: begin
                if (at_bad) begin
                  done_q   <= 1'b1;
                  status_q <= ST_RANGE;
                  data_q   <= '0;
                end else begin
                  rd_q    <= CW'(pos_x);
                  wr_q    <= pos_m1;
                  left_q  <= left_del;
                  state_q <= (left_del == '0) ? S_FIN : S_RD;
                end
              end
              ACT_GET: begin
                if (at_bad) begin
                  done_q   <= 1'b1;
                  status_q <= ST_RANGE;
                  data_q   <= '0;
                end else begin
                  rd_q    <= pos_m1;
                  state_q <= S_RD;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_RD: begin
          // read data lands in the next cycle
          state_q <= S_WR;
        end
        S_WR: begin
          if (op_q == ACT_GET) begin
            done_q   <= 1'b1;
            status_q <= ST_OK;
            data_q   <= mem_rdata;
            state_q  <= S_IDLE;
          end else begin
            wr_q    <= rd_q;
            rd_q    <= rd_step;
            left_q  <= left_q - CW'(1);
            state_q <= (left_q == CW'(1)) ? S_FIN : S_RD;
          end
        end
        S_FIN: begin
          fill_q   <= (op_q == ACT_INSERT) ? (fill_q + CW'(1)) : (fill_q - CW'(1));
          done_q   <= 1'b1;
          status_q <= ST_OK;
          data_q   <= '0;
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign data_o   = data_q;
  // length after the request, low bits only
  assign count_o  = COUNT_W'(fill_q);

endmodule

/* src/ple_ram.sv */
// entry store of the positional list engine: one write port, one read port
// with registered read data; uses ple_pkg
module ple_ram
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
